// ===== design/pdmsd_pkg.sv =====
// Shared types, constants and the 64-tap windowed-sinc coefficient table
// for the PDM decimator. No dependencies.
package pdmsd_pkg;

  localparam int TAPS               = 64;
  localparam int LANES              = 16;
  localparam int OUT_BUFFER_SAMPLES = 256;
  localparam int WORDS_PER_GROUP    = TAPS / LANES;
  localparam int WIDX_W             = $clog2(WORDS_PER_GROUP);
  localparam int LANE_W             = $clog2(LANES);
  localparam int TAP_W              = $clog2(TAPS);
  localparam int FILL_W             = (OUT_BUFFER_SAMPLES > 1) ?
                                      $clog2(OUT_BUFFER_SAMPLES) : 1;
  localparam int COEFF_W            = 12;
  localparam int ACC_W              = 16;
  localparam int DISC_W             = 8;

  localparam logic [WIDX_W-1:0] LAST_WORD   = WIDX_W'(WORDS_PER_GROUP - 1);
  localparam logic [FILL_W-1:0] LAST_FILL   = FILL_W'(OUT_BUFFER_SAMPLES - 1);
  localparam logic [ACC_W-1:0]  PCM_OFFSET  = ACC_W'(1 << 15);

  typedef logic [COEFF_W-1:0] coeff_t;
  typedef coeff_t [LANES-1:0] lane_vec_t;

  typedef struct packed {
    logic [15:0] pdm_word;
    logic        restart;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               buffer_last;
  } out_word_t;

  localparam coeff_t COEFF_TABLE [TAPS] = '{
    12'd0,    12'd2,    12'd9,    12'd21,   12'd39,   12'd63,   12'd94,   12'd132,
    12'd179,  12'd236,  12'd302,  12'd379,  12'd467,  12'd565,  12'd674,  12'd792,
    12'd920,  12'd1055, 12'd1196, 12'd1341, 12'd1487, 12'd1633, 12'd1776, 12'd1913,
    12'd2042, 12'd2159, 12'd2263, 12'd2352, 12'd2422, 12'd2474, 12'd2506, 12'd2516,
    12'd2506, 12'd2474, 12'd2422, 12'd2352, 12'd2263, 12'd2159, 12'd2042, 12'd1913,
    12'd1776, 12'd1633, 12'd1487, 12'd1341, 12'd1196, 12'd1055, 12'd920,  12'd792,
    12'd674,  12'd565,  12'd467,  12'd379,  12'd302,  12'd236,  12'd179,  12'd132,
    12'd94,   12'd63,   12'd39,   12'd21,   12'd9,    12'd2,    12'd0,    12'd0
  };

endpackage

// ===== design/pdmsd_lane.sv =====
// One filter lane: picks the coefficient of its tap and gates it by the PDM bit.
// Depends on pdmsd_pkg.
module pdmsd_lane (
  input  logic                            pdm_bit,
  input  logic [pdmsd_pkg::WIDX_W-1:0]    word_idx,
  input  logic [pdmsd_pkg::LANE_W-1:0]    lane_idx,
  output pdmsd_pkg::coeff_t               gated
);
  import pdmsd_pkg::*;

  logic [TAP_W-1:0] tap;

  assign tap   = {word_idx, lane_idx};
  assign gated = pdm_bit ? COEFF_TABLE[tap] : '0;

endmodule

// ===== design/pdmsd_merge.sv =====
// Merge stage: adder tree over all lane outputs plus the running sum.
// Depends on pdmsd_pkg.
module pdmsd_merge (
  input  pdmsd_pkg::lane_vec_t            lanes,
  input  logic [pdmsd_pkg::ACC_W-1:0]     acc_base,
  output logic [pdmsd_pkg::ACC_W-1:0]     sum
);
  import pdmsd_pkg::*;

  logic [ACC_W-1:0] l1 [8];
  logic [ACC_W-1:0] l2 [4];
  logic [ACC_W-1:0] l3 [2];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      l1[i] = ACC_W'(lanes[2*i]) + ACC_W'(lanes[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = l1[2*i] + l1[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = l2[2*i] + l2[2*i+1];
    end
    sum = acc_base + l3[0] + l3[1];
  end

endmodule

// ===== design/pdm_sinc_decimator_core.sv =====
// Top level of the PDM to PCM decimator (decimation by 64, windowed sinc).
// Depends on pdmsd_pkg, pdmsd_lane and pdmsd_merge.
//
// Usage:
//   in_*   : one 16-bit PDM word per handshake, oldest bit in bit 0, plus a
//            restart flag that opens a new capture before the word is used.
//   out_*  : one signed PCM word for every fourth input word, except in
//            discarded buffers; buffer_last marks each output buffer end.
//   cfg_*  : write of discard_buffers; sampled only when restart is seen.
// Output: the PCM word appears in the cycle after the fourth input word.
// Throughput: one input word per cycle while in_ready is high. Sixteen
//   lanes gate their taps in parallel and one adder tree folds them into
//   the accumulator, so a word is fully absorbed in the cycle it is accepted.
// Stall: the result sits in a single output register. Input words that do
//   not finish a delivered sample are always taken; only a word that would
//   produce a sample waits while the previous sample is still unread.
// Reset: synchronous, active low; clears accumulator, word index, fill count,
//   discard count, configured discard value and output valid; payload not reset.
module pdm_sinc_decimator_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pdmsd_pkg::in_word_t    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pdmsd_pkg::out_word_t   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);
  import pdmsd_pkg::*;

  logic [ACC_W-1:0]  acc_r,  acc_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [DISC_W-1:0] disc_left_r, disc_left_nxt;
  logic [DISC_W-1:0] disc_cfg_r;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r,  out_data_nxt;

  // State as seen after a possible restart of this word
  logic [ACC_W-1:0]  acc_eff;
  logic [WIDX_W-1:0] widx_eff;
  logic [FILL_W-1:0] fill_eff;
  logic [DISC_W-1:0] disc_eff;

  lane_vec_t         lane_out;
  logic [ACC_W-1:0]  sum;
  logic              in_fire;
  logic              group_end;
  logic              emit;
  logic              buf_last;

  assign acc_eff  = in_data.restart ? '0 : acc_r;
  assign widx_eff = in_data.restart ? '0 : widx_r;
  assign fill_eff = in_data.restart ? '0 : fill_r;
  assign disc_eff = in_data.restart ? disc_cfg_r : disc_left_r;

  // Lanes: one per bit of the PDM word
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pdmsd_lane u_lane (
      .pdm_bit  (in_data.pdm_word[g]),
      .word_idx (widx_eff),
      .lane_idx (LANE_W'(g)),
      .gated    (lane_out[g])
    );
  end

  pdmsd_merge u_merge (
    .lanes    (lane_out),
    .acc_base (acc_eff),
    .sum      (sum)
  );

  assign group_end = (widx_eff == LAST_WORD);
  assign emit      = group_end && (disc_eff == '0);
  assign buf_last  = (fill_eff == LAST_FILL);

  // Only a sample-producing word has to wait for the output register
  assign in_ready  = !out_valid_r || out_ready || !emit;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    acc_nxt       = acc_r;
    widx_nxt      = widx_r;
    fill_nxt      = fill_r;
    disc_left_nxt = disc_left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      fill_nxt      = fill_eff;
      disc_left_nxt = disc_eff;
      if (!group_end) begin
        acc_nxt  = sum;
        widx_nxt = widx_eff + WIDX_W'(1);
      end else begin
        acc_nxt  = '0;
        widx_nxt = '0;
        if (emit) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.pcm_sample = $signed(sum - PCM_OFFSET);
          out_data_nxt.buffer_last = buf_last;
        end
        if (buf_last) begin
          fill_nxt = '0;
          if (disc_eff != '0) begin
            disc_left_nxt = disc_eff - DISC_W'(1);
          end
        end else begin
          fill_nxt = fill_eff + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      widx_r      <= '0;
      fill_r      <= '0;
      disc_left_r <= '0;
      disc_cfg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      widx_r      <= widx_nxt;
      fill_r      <= fill_nxt;
      disc_left_r <= disc_left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        disc_cfg_r <= cfg_data;
      end
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
